### design/sha512_pkg.sv
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types and constants for the SHA-512 streaming hash engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

  typedef struct packed {
    logic [63:0] message_word;
    logic        word_present;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_item_t;

  // queue entry from front to back: a word to push, or a digest request
  typedef enum logic [1:0] {
    CMD_WORD   = 2'd0,
    CMD_DIGEST = 2'd1
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [63:0] word;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_ROUND  = 2'd1,
    BK_UPDATE = 2'd2,
    BK_EMIT   = 2'd3
  } bk_state_t;

  typedef enum logic [1:0] {
    FR_IDLE = 2'd0,
    FR_PAD  = 2'd1,
    FR_LEN  = 2'd2,
    FR_DIG  = 2'd3
  } fr_state_t;

  localparam int unsigned ROUNDS = 80;
  localparam logic [63:0] PAD_WORD = 64'h8000000000000000;

  localparam logic [63:0] INIT_HASH [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] ror64(input logic [63:0] x, input int unsigned n);
    ror64 = (x >> n) | (x << (64 - n));
  endfunction

endpackage

### design/sha512_front.sv
// ----------------------------------------------------------------------------
// sha512_front
// Accepts message items, counts words and block position, and expands a last
// item into padding words and a digest request for the back end.
// ----------------------------------------------------------------------------
module sha512_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sha512_pkg::in_item_t in_data,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output sha512_pkg::cmd_t     cmd_data
);

  sha512_pkg::fr_state_t state_r, state_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [57:0] count_r, count_nxt;
  logic        mark_r, mark_nxt;
  logic        take;

  // input is taken only while not expanding padding
  assign in_ready = (state_r == sha512_pkg::FR_IDLE) && cmd_ready;
  assign take     = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha512_pkg::FR_IDLE:
        if (take && in_data.last_word) state_nxt = sha512_pkg::FR_PAD;
      sha512_pkg::FR_PAD:
        if (cmd_ready && !mark_r && pos_r == 4'd14) state_nxt = sha512_pkg::FR_LEN;
      sha512_pkg::FR_LEN:
        if (cmd_ready) state_nxt = sha512_pkg::FR_DIG;
      sha512_pkg::FR_DIG:
        if (cmd_ready) state_nxt = sha512_pkg::FR_IDLE;
      default: state_nxt = sha512_pkg::FR_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    cmd_valid     = 1'b0;
    cmd_data.op   = sha512_pkg::CMD_WORD;
    cmd_data.word = in_data.message_word;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    case (state_r)
      sha512_pkg::FR_IDLE: begin
        cmd_valid = in_valid && in_data.word_present;
        if (take && in_data.word_present) begin
          pos_nxt   = pos_r + 4'd1;
          count_nxt = count_r + 58'd1;
        end
      end
      sha512_pkg::FR_PAD: begin
        // first pad word is the marker; this state emits one word a transfer
        cmd_valid     = 1'b1;
        cmd_data.word = mark_r ? sha512_pkg::PAD_WORD : 64'd0;
        if (cmd_ready) pos_nxt = pos_r + 4'd1;
      end
      sha512_pkg::FR_LEN: begin
        cmd_valid     = 1'b1;
        cmd_data.word = {count_r, 6'd0};
        if (cmd_ready) pos_nxt = 4'd0;
      end
      sha512_pkg::FR_DIG: begin
        cmd_valid   = 1'b1;
        cmd_data.op = sha512_pkg::CMD_DIGEST;
        if (cmd_ready) count_nxt = '0;
      end
      default: ;
    endcase
  end

  // the marker word needs its own slot: pad state starts with it pending
  always_comb begin
    mark_nxt = mark_r;
    if (take && in_data.last_word) mark_nxt = 1'b1;
    else if (state_r == sha512_pkg::FR_PAD && cmd_ready) mark_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha512_pkg::FR_IDLE;
      pos_r   <= '0;
      count_r <= '0;
      mark_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
      mark_r  <= mark_nxt;
    end
  end

endmodule

### design/sha512_fifo.sv
// ----------------------------------------------------------------------------
// sha512_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module sha512_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  sha512_pkg::cmd_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output sha512_pkg::cmd_t rd_data
);

  localparam int unsigned AW = $clog2(DEPTH);

  sha512_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          wr_en, rd_en;

  assign wr_ready = cnt_r != DEPTH[AW:0];
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + {{AW{1'b0}}, wr_en} - {{AW{1'b0}}, rd_en};
    end
  end

  no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH[AW:0]) else $error("queue count above depth");
  count_track: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && !rd_en |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");
  no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid |-> cnt_r != '0) else $error("read from empty queue");

endmodule

### design/sha512_back.sv
// ----------------------------------------------------------------------------
// sha512_back
// Loads words into the 16-word window, runs 80 rounds per block (one a
// cycle), folds into the chain value and streams out digests.
// ----------------------------------------------------------------------------
module sha512_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  sha512_pkg::cmd_t      cmd_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha512_pkg::out_item_t out_data
);

  sha512_pkg::bk_state_t state_r, state_nxt;
  logic [63:0] h_r   [8];
  logic [63:0] v_r   [8];
  logic [63:0] w_r   [16];
  logic [3:0]  pos_r;
  logic [6:0]  rnd_r;
  logic [2:0]  idx_r;
  logic        take, full;

  logic [63:0] wt, x2, x15, s0, s1, t1, t2, e_s, a_s, ch, mj, wnew;

  assign cmd_ready = state_r == sha512_pkg::BK_IDLE;
  assign take      = cmd_valid && cmd_ready;
  assign full      = take && cmd_data.op == sha512_pkg::CMD_WORD && pos_r == 4'd15;

  // schedule: window shifts, w_r[0] is current word
  assign x2   = w_r[14];
  assign x15  = w_r[1];
  assign s1   = sha512_pkg::ror64(x2, 19) ^ sha512_pkg::ror64(x2, 61) ^ (x2 >> 6);
  assign s0   = sha512_pkg::ror64(x15, 1) ^ sha512_pkg::ror64(x15, 8) ^ (x15 >> 7);
  assign wnew = s1 + w_r[9] + s0 + w_r[0];
  assign wt   = w_r[0];

  // round function
  assign e_s = sha512_pkg::ror64(v_r[4], 14) ^ sha512_pkg::ror64(v_r[4], 18) ^
               sha512_pkg::ror64(v_r[4], 41);
  assign a_s = sha512_pkg::ror64(v_r[0], 28) ^ sha512_pkg::ror64(v_r[0], 34) ^
               sha512_pkg::ror64(v_r[0], 39);
  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign mj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + e_s + ch + sha512_pkg::ROUND_K[rnd_r] + wt;
  assign t2  = a_s + mj;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha512_pkg::BK_IDLE: begin
        if (full) state_nxt = sha512_pkg::BK_ROUND;
        else if (take && cmd_data.op == sha512_pkg::CMD_DIGEST)
          state_nxt = sha512_pkg::BK_EMIT;
      end
      sha512_pkg::BK_ROUND:
        if (rnd_r == 7'(sha512_pkg::ROUNDS - 1)) state_nxt = sha512_pkg::BK_UPDATE;
      sha512_pkg::BK_UPDATE: state_nxt = sha512_pkg::BK_IDLE;
      sha512_pkg::BK_EMIT:
        if (out_ready && idx_r == 3'd7) state_nxt = sha512_pkg::BK_IDLE;
      default: state_nxt = sha512_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_valid             = state_r == sha512_pkg::BK_EMIT;
    out_data.digest_word  = h_r[idx_r];
    out_data.digest_index = idx_r;
    out_data.digest_last  = idx_r == 3'd7;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      sha512_pkg::BK_IDLE: begin
        if (take && cmd_data.op == sha512_pkg::CMD_WORD) begin
          // window fills from the top; w_r[0] holds word 0 once full
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= cmd_data.word;
        end
        if (full) for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      sha512_pkg::BK_ROUND: begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wnew;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      default: ;
    endcase
  end

  // control and chain value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha512_pkg::BK_IDLE;
      pos_r   <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha512_pkg::INIT_HASH[i];
    end else begin
      state_r <= state_nxt;
      if (take && cmd_data.op == sha512_pkg::CMD_WORD) pos_r <= pos_r + 4'd1;
      if (state_r == sha512_pkg::BK_ROUND)
        rnd_r <= (rnd_r == 7'(sha512_pkg::ROUNDS - 1)) ? '0 : rnd_r + 7'd1;
      if (state_r == sha512_pkg::BK_UPDATE)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      if (out_valid && out_ready) begin
        idx_r <= idx_r + 3'd1;
        if (idx_r == 3'd7)
          for (int i = 0; i < 8; i++) h_r[i] <= sha512_pkg::INIT_HASH[i];
      end
    end
  end

  rounds_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha512_pkg::BK_UPDATE |-> $past(rnd_r) == 7'(sha512_pkg::ROUNDS - 1))
    else $error("block folded early");
  digest_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha512_pkg::BK_EMIT |-> pos_r == 4'd0) else $error("digest mid-block");
  rounds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != sha512_pkg::BK_ROUND |-> rnd_r == '0) else $error("round count stray");

endmodule

### design/sha512_hash_engine_core.sv
// ----------------------------------------------------------------------------
// sha512_hash_engine_core
// Streaming SHA-512 over whole 64-bit words with padding and digest output.
//
//   channel | ports                       | payload
//   input   | in_valid / in_ready         | in_data  (message word, flags)
//   output  | out_valid / out_ready       | out_data (digest word, index)
//
// Each 16th word taken starts 80 rounds plus one fold into the chain value
// in the back end. A last item adds up to 18 pad words, one or two blocks,
// then 8 digest transfers. Reset is synchronous, active low. The command
// queue lets the front keep taking words while rounds run, until it fills.
// ----------------------------------------------------------------------------
module sha512_hash_engine_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha512_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha512_pkg::out_item_t out_data
);

  logic             f_valid, f_ready, b_valid, b_ready;
  sha512_pkg::cmd_t f_data, b_data;

  sha512_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data)
  );

  sha512_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  sha512_back u_back (
    .clk, .rst_n,
    .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd_data(b_data),
    .out_valid, .out_ready, .out_data
  );

endmodule
